// ----- design/ptl_pkg.sv -----
package ptl_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int ID_W = 4;
	localparam int PTR_W = ID_W + 1;
	localparam logic [PTR_W-1:0] END_PTR = PTR_W'(NUM_TIMERS);

	localparam int EXP_W = 32;
	localparam int DLY_W = 16;
	localparam int TPS_W = 14;
	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(100);

	// delay_ms * tps / 1000 via reciprocal multiply plus one correction step
	localparam int PROD_W = DLY_W + TPS_W;
	localparam int MS_PER_S = 1000;
	localparam int RECIP_SHIFT = 40;
	localparam int RECIP_W = 31;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / MS_PER_S);
	localparam int WIDE_W = PROD_W + RECIP_W;
	localparam int QUOT_W = 21;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 8;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_MODIFY  = 3'd1,
		OP_SET_REL = 3'd2,
		OP_CANCEL  = 3'd3,
		OP_SWEEP   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PENDING   = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_REPLY  = 3'd0,
		K_ADD    = 3'd1,
		K_SET    = 3'd2,
		K_CANCEL = 3'd3,
		K_SWEEP  = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   id;
		status_t           status;
		logic [EXP_W-1:0]  expiry;
		logic [EXP_W-1:0]  now;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            fired;
		status_t         status;
		logic            last;
	} res_t;

endpackage

// ----- design/ptl_front.sv -----
module ptl_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_valid,
	output logic                              s_ready,
	input  logic [ptl_pkg::S_TDATA_W-1:0]     s_data,
	input  logic [2:0]                        s_user,
	input  logic                              cfg_we,
	input  logic [ptl_pkg::TPS_W-1:0]         cfg_wdata,
	output logic                              push,
	output ptl_pkg::cmd_t                     push_cmd,
	input  logic                              full
);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_MUL   = 5'b00010,
		F_RECIP = 5'b00100,
		F_FIX   = 5'b01000,
		F_PUSH  = 5'b10000
	} fstate_t;

	fstate_t                          state_q;
	logic [ptl_pkg::TPS_W-1:0]        tps_q;
	ptl_pkg::cmd_t                    cmd_q;
	ptl_pkg::cmd_t                    cmd_d;
	logic [ptl_pkg::DLY_W-1:0]        delay_q;
	logic [ptl_pkg::PROD_W-1:0]       prod_s1;
	logic [ptl_pkg::QUOT_W-1:0]       quot_s2;
	logic [ptl_pkg::WIDE_W-1:0]       wide;
	logic [ptl_pkg::PROD_W-1:0]       qe_x;
	logic [ptl_pkg::PROD_W-1:0]       rem;
	logic [ptl_pkg::QUOT_W-1:0]       ticks;
	logic [ptl_pkg::ID_W-1:0]         in_id;
	logic                             in_valid_id;
	logic                             need_mul;

	assign s_ready  = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !full;
	assign push_cmd = cmd_q;

	assign in_id       = s_data[ptl_pkg::ID_W-1:0];
	assign in_valid_id = {1'b0, in_id} < ptl_pkg::END_PTR;

	always_comb begin
		cmd_d        = '0;
		cmd_d.kind   = ptl_pkg::K_REPLY;
		cmd_d.id     = in_id;
		cmd_d.status = ptl_pkg::ST_OK;
		cmd_d.expiry = s_data[4 +: ptl_pkg::EXP_W];
		cmd_d.now    = s_data[52 +: ptl_pkg::EXP_W];
		need_mul     = 1'b0;
		case (ptl_pkg::op_t'(s_user))
			ptl_pkg::OP_ADD: begin
				if (in_valid_id)
					cmd_d.kind = ptl_pkg::K_ADD;
			end
			ptl_pkg::OP_MODIFY: begin
				if (in_valid_id)
					cmd_d.kind = ptl_pkg::K_SET;
			end
			ptl_pkg::OP_SET_REL: begin
				if (in_valid_id) begin
					cmd_d.kind = ptl_pkg::K_SET;
					need_mul   = 1'b1;
				end
			end
			ptl_pkg::OP_CANCEL: begin
				if (in_valid_id)
					cmd_d.kind = ptl_pkg::K_CANCEL;
				else
					cmd_d.status = ptl_pkg::ST_NOT_FOUND;
			end
			ptl_pkg::OP_SWEEP: begin
				cmd_d.kind = ptl_pkg::K_SWEEP;
			end
			default: begin
				cmd_d.kind = ptl_pkg::K_REPLY;
			end
		endcase
	end

	assign wide  = ptl_pkg::WIDE_W'(prod_s1) * ptl_pkg::WIDE_W'(ptl_pkg::RECIP);
	assign qe_x  = ptl_pkg::PROD_W'(quot_s2) * ptl_pkg::PROD_W'(ptl_pkg::MS_PER_S);
	assign rem   = prod_s1 - qe_x;
	assign ticks = quot_s2 + ptl_pkg::QUOT_W'(rem >= ptl_pkg::PROD_W'(ptl_pkg::MS_PER_S));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			tps_q   <= ptl_pkg::TPS_RESET;
		end else begin
			if (cfg_we)
				tps_q <= cfg_wdata;
			case (state_q)
				F_IDLE: begin
					if (s_valid)
						state_q <= need_mul ? F_MUL : F_PUSH;
				end
				F_MUL:   state_q <= F_RECIP;
				F_RECIP: state_q <= F_FIX;
				F_FIX:   state_q <= F_PUSH;
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && s_valid) begin
			cmd_q   <= cmd_d;
			delay_q <= s_data[36 +: ptl_pkg::DLY_W];
		end
		if (state_q == F_MUL)
			prod_s1 <= ptl_pkg::PROD_W'(delay_q) * ptl_pkg::PROD_W'(tps_q);
		if (state_q == F_RECIP)
			quot_s2 <= wide[ptl_pkg::RECIP_SHIFT +: ptl_pkg::QUOT_W];
		if (state_q == F_FIX)
			cmd_q.expiry <= cmd_q.now + ptl_pkg::EXP_W'(ticks);
	end

endmodule

// ----- design/ptl_cmd_fifo.sv -----
module ptl_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ptl_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output ptl_pkg::cmd_t pop_cmd,
	output logic          empty
);

	ptl_pkg::cmd_t                 mem_q [ptl_pkg::FIFO_DEPTH];
	logic [ptl_pkg::FIFO_AW-1:0]   wr_q;
	logic [ptl_pkg::FIFO_AW-1:0]   rd_q;
	logic [ptl_pkg::FIFO_AW:0]     cnt_q;

	assign full    = cnt_q == (ptl_pkg::FIFO_AW+1)'(ptl_pkg::FIFO_DEPTH);
	assign empty   = cnt_q == '0;
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

endmodule

// ----- design/ptl_back.sv -----
module ptl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  ptl_pkg::cmd_t cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output ptl_pkg::res_t out_res
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_WALK = 2'b10
	} bstate_t;

	localparam int ID_W = ptl_pkg::ID_W;
	localparam int PTR_W = ptl_pkg::PTR_W;

	bstate_t                       state_q, state_d;
	logic [ptl_pkg::EXP_W-1:0]     expiry_q [ptl_pkg::NUM_TIMERS];
	logic [ID_W-1:0]               link_q [ptl_pkg::NUM_TIMERS];
	logic [ptl_pkg::NUM_TIMERS-1:0] pending_q, pending_d;
	logic [PTR_W-1:0]              head_q, head_d, tail_q, tail_d;
	logic [PTR_W-1:0]              cur_q, cur_d, prev_q, prev_d;
	logic                          hold_valid_q, hold_valid_d;
	logic [ID_W-1:0]               hold_id_q, hold_id_d;
	ptl_pkg::kind_t                wkind_q;
	logic [ID_W-1:0]               wid_q;
	logic [ptl_pkg::EXP_W-1:0]     wnow_q;
	logic                          latch;

	logic                          out_valid_q;
	ptl_pkg::res_t                 out_q;
	logic                          emit;
	ptl_pkg::res_t                 emit_res;
	logic                          out_free;

	logic                          exp_we;
	logic [ID_W-1:0]               exp_wa;
	logic                          link_we;
	logic [ID_W-1:0]               link_wa, link_wd;

	logic [ID_W-1:0]               cur_id;
	logic [PTR_W-1:0]              nxt;
	logic [ptl_pkg::EXP_W-1:0]     diff;
	logic [PTR_W-1:0]              unl_head;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cur_id   = cur_q[ID_W-1:0];
	assign nxt      = (cur_q == tail_q) ? ptl_pkg::END_PTR : {1'b0, link_q[cur_id]};
	assign diff     = expiry_q[cur_id] - wnow_q;
	assign unl_head = (prev_q == ptl_pkg::END_PTR) ? nxt : head_q;

	always_comb begin
		state_d      = state_q;
		pending_d    = pending_q;
		head_d       = head_q;
		tail_d       = tail_q;
		cur_d        = cur_q;
		prev_d       = prev_q;
		hold_valid_d = hold_valid_q;
		hold_id_d    = hold_id_q;
		latch        = 1'b0;
		pop          = 1'b0;
		emit         = 1'b0;
		emit_res     = '{id: cmd.id, fired: 1'b0, status: cmd.status, last: 1'b1};
		exp_we       = 1'b0;
		exp_wa       = cmd.id;
		link_we      = 1'b0;
		link_wa      = tail_q[ID_W-1:0];
		link_wd      = cmd.id;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					case (cmd.kind)
						ptl_pkg::K_ADD, ptl_pkg::K_SET: begin
							if (out_free) begin
								pop  = 1'b1;
								emit = 1'b1;
								emit_res.status = ptl_pkg::ST_OK;
								if (cmd.kind == ptl_pkg::K_ADD && pending_q[cmd.id]) begin
									emit_res.status = ptl_pkg::ST_PENDING;
								end else begin
									exp_we = 1'b1;
									if (!pending_q[cmd.id]) begin
										if (tail_q == ptl_pkg::END_PTR)
											head_d = {1'b0, cmd.id};
										else
											link_we = 1'b1;
										tail_d = {1'b0, cmd.id};
										pending_d[cmd.id] = 1'b1;
									end
								end
							end
						end
						ptl_pkg::K_CANCEL, ptl_pkg::K_SWEEP: begin
							pop          = 1'b1;
							latch        = 1'b1;
							cur_d        = head_q;
							prev_d       = ptl_pkg::END_PTR;
							hold_valid_d = 1'b0;
							state_d      = B_WALK;
						end
						default: begin
							if (out_free) begin
								pop  = 1'b1;
								emit = 1'b1;
							end
						end
					endcase
				end
			end
			B_WALK: begin
				link_wa = prev_q[ID_W-1:0];
				link_wd = nxt[ID_W-1:0];
				if (cur_q == ptl_pkg::END_PTR) begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = B_IDLE;
						if (wkind_q == ptl_pkg::K_CANCEL)
							emit_res = '{id: wid_q, fired: 1'b0,
								status: ptl_pkg::ST_NOT_FOUND, last: 1'b1};
						else if (hold_valid_q)
							emit_res = '{id: hold_id_q, fired: 1'b1,
								status: ptl_pkg::ST_OK, last: 1'b1};
						else
							emit_res = '{id: '0, fired: 1'b0,
								status: ptl_pkg::ST_OK, last: 1'b1};
					end
				end else if (wkind_q == ptl_pkg::K_CANCEL) begin
					if (cur_id == wid_q) begin
						if (out_free) begin
							emit     = 1'b1;
							emit_res = '{id: wid_q, fired: 1'b0,
								status: ptl_pkg::ST_OK, last: 1'b1};
							link_we  = prev_q != ptl_pkg::END_PTR;
							head_d   = unl_head;
							if (cur_q == tail_q)
								tail_d = prev_q;
							if (unl_head == ptl_pkg::END_PTR)
								tail_d = ptl_pkg::END_PTR;
							pending_d[cur_id] = 1'b0;
							state_d  = B_IDLE;
						end
					end else begin
						prev_d = cur_q;
						cur_d  = nxt;
					end
				end else if (diff[ptl_pkg::EXP_W-1]) begin
					if (!hold_valid_q || out_free) begin
						emit     = hold_valid_q;
						emit_res = '{id: hold_id_q, fired: 1'b1,
							status: ptl_pkg::ST_OK, last: 1'b0};
						link_we  = prev_q != ptl_pkg::END_PTR;
						head_d   = unl_head;
						if (cur_q == tail_q)
							tail_d = prev_q;
						if (unl_head == ptl_pkg::END_PTR)
							tail_d = ptl_pkg::END_PTR;
						pending_d[cur_id] = 1'b0;
						hold_valid_d = 1'b1;
						hold_id_d    = cur_id;
						cur_d        = nxt;
					end
				end else begin
					prev_d = cur_q;
					cur_d  = nxt;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			pending_q    <= '0;
			head_q       <= ptl_pkg::END_PTR;
			tail_q       <= ptl_pkg::END_PTR;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pending_q    <= pending_d;
			head_q       <= head_d;
			tail_q       <= tail_d;
			hold_valid_q <= hold_valid_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		prev_q    <= prev_d;
		hold_id_q <= hold_id_d;
		if (latch) begin
			wkind_q <= cmd.kind;
			wid_q   <= cmd.id;
			wnow_q  <= cmd.now;
		end
		if (emit)
			out_q <= emit_res;
		if (exp_we)
			expiry_q[exp_wa] <= cmd.expiry;
		if (link_we)
			link_q[link_wa] <= link_wd;
	end

endmodule

// ----- design/pending_timer_list_core.sv -----
// Pending timer list: a table of 16 timers, each with a 32-bit expiry tick,
// chained in insertion order while pending.
// Input stream (s_axis): one beat per operation; tuser carries the opcode
// (add, modify, set relative, cancel, sweep). Output stream (m_axis): one beat
// per result; tlast marks the final result of an operation, tuser marks a
// timer fired by a sweep.
// cfg_we/cfg_wdata load the tick rate used by set relative (reset 100).
// The front end takes a new beat only once it has pushed the last one (set
// relative runs a multiply, a reciprocal multiply and a correction step)
// and queues decoded commands in a 4-entry FIFO. The back end answers add,
// modify, set relative and bad opcodes from the FIFO head; cancel and
// sweep walk the list one entry per cycle unless m_axis stalls the walk.
// Simple results pass the command register, FIFO and output register.
// Reset empties the list and clears every pending mark; nothing else needs
// clearing. A stalled m_axis holds its beat; the back end stops when it has
// a new result and the output register is full, then the FIFO fills and
// s_axis_tready drops.
module pending_timer_list_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// timer_id[3:0], expiry_value[35:4], delay_ms[51:36], now[83:52], zero pad
	input  logic [ptl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// op[2:0]
	input  logic [2:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// result_timer[3:0], status[5:4], zero pad
	output logic [ptl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// fired
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [ptl_pkg::TPS_W-1:0]         cfg_wdata
);

	logic          push, full, pop, empty;
	ptl_pkg::cmd_t push_cmd, pop_cmd;
	ptl_pkg::res_t res;

	ptl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.s_data    (s_axis_tdata),
		.s_user    (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full)
	);

	ptl_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	ptl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {2'b00, res.status, res.id};
	assign m_axis_tuser = res.fired;
	assign m_axis_tlast = res.last;

endmodule

// ----- design/ptl_checker.sv -----
module ptl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [ptl_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tuser,
	input logic                          m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("front end took two beats back to back");

	a_plain_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("non-fired result without tlast");

	a_fired_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[5:4] == ptl_pkg::ST_OK)
		else $error("fired result with error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[5:4] != 2'd3 && m_axis_tdata[7:6] == 2'd0)
		else $error("bad status code or pad bits");

endmodule

bind pending_timer_list_core ptl_checker u_ptl_checker (.*);

// ----- test/pending_timer_list_core_tb.sv -----
module pending_timer_list_core_tb;
	import ptl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_SEG = 63;
	localparam int SETTLE_CYCLES = 24;

	typedef struct {
		logic [2:0]       op;
		logic [ID_W-1:0]  id;
		logic [EXP_W-1:0] expv;
		logic [DLY_W-1:0] dly;
		logic [EXP_W-1:0] nowv;
		bit               typed;
		res_t             want;
	} stim_row_t;

	bit                 clk;
	bit                 arst_n;
	bit                 s_axis_tvalid;
	logic               s_axis_tready;
	bit [S_TDATA_W-1:0] s_axis_tdata;
	bit [2:0]           s_axis_tuser;
	logic               m_axis_tvalid;
	bit                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;
	bit                 cfg_we;
	bit [TPS_W-1:0]     cfg_wdata;

	pending_timer_list_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// timer list mirror
	logic [EXP_W-1:0] exp_tick [NUM_TIMERS];
	bit               armed    [NUM_TIMERS];
	logic [PTR_W-1:0] link     [NUM_TIMERS];
	logic [PTR_W-1:0] chain_head;
	logic [PTR_W-1:0] chain_tail;
	logic [TPS_W-1:0] tick_rate;

	res_t step_results[$];
	res_t due_results[$];

	int errors;
	int cycles;
	int ops_sent;
	int beats_seen;
	int fired_seen;
	int src_idle;
	int dst_idle;

	function automatic logic [PTR_W-1:0] next_in_chain(logic [PTR_W-1:0] cur);
		if (cur == chain_tail)
			return END_PTR;
		return (link[cur[ID_W-1:0]] < END_PTR) ? link[cur[ID_W-1:0]] : END_PTR;
	endfunction

	function automatic void chain_append(logic [ID_W-1:0] id);
		link[id] = END_PTR;
		if (chain_tail >= END_PTR)
			chain_head = PTR_W'(id);
		else
			link[chain_tail[ID_W-1:0]] = PTR_W'(id);
		chain_tail = PTR_W'(id);
		armed[id] = 1'b1;
	endfunction

	function automatic void chain_drop(logic [PTR_W-1:0] prev, logic [PTR_W-1:0] cur,
			logic [PTR_W-1:0] nxt);
		if (prev >= END_PTR)
			chain_head = nxt;
		else
			link[prev[ID_W-1:0]] = nxt;
		if (cur == chain_tail)
			chain_tail = prev;
		if (chain_head >= END_PTR)
			chain_tail = END_PTR;
		armed[cur[ID_W-1:0]] = 1'b0;
	endfunction

	// result beats one operation produces, left in step_results
	function automatic void timer_list_step(logic [2:0] op, logic [ID_W-1:0] id,
			logic [EXP_W-1:0] expv, logic [DLY_W-1:0] dly, logic [EXP_W-1:0] nowv);
		logic [PTR_W-1:0] prev;
		logic [PTR_W-1:0] cur;
		logic [PTR_W-1:0] nxt;
		logic [EXP_W-1:0] gap;
		logic [63:0]      ticks;
		status_t          st;
		int               hits;
		bit               found;
		step_results.delete();
		case (op)
			OP_ADD: begin
				st = ST_OK;
				if (armed[id]) begin
					st = ST_PENDING;
				end else begin
					exp_tick[id] = expv;
					chain_append(id);
				end
				step_results.push_back(res_t'{id, 1'b0, st, 1'b1});
			end
			OP_MODIFY, OP_SET_REL: begin
				ticks = 64'(dly) * 64'(tick_rate) / 64'(MS_PER_S);
				exp_tick[id] = (op == OP_SET_REL) ? nowv + ticks[EXP_W-1:0] : expv;
				if (!armed[id])
					chain_append(id);
				step_results.push_back(res_t'{id, 1'b0, ST_OK, 1'b1});
			end
			OP_CANCEL: begin
				st = ST_NOT_FOUND;
				found = 1'b0;
				prev = END_PTR;
				cur = chain_head;
				for (int n = 0; n < NUM_TIMERS && cur < END_PTR && !found; n++) begin
					nxt = next_in_chain(cur);
					if (cur[ID_W-1:0] == id) begin
						chain_drop(prev, cur, nxt);
						st = ST_OK;
						found = 1'b1;
					end else begin
						prev = cur;
						cur = nxt;
					end
				end
				step_results.push_back(res_t'{id, 1'b0, st, 1'b1});
			end
			OP_SWEEP: begin
				hits = 0;
				prev = END_PTR;
				cur = chain_head;
				for (int n = 0; n < NUM_TIMERS && cur < END_PTR; n++) begin
					nxt = next_in_chain(cur);
					gap = exp_tick[cur[ID_W-1:0]] - nowv;
					if (gap[EXP_W-1]) begin
						chain_drop(prev, cur, nxt);
						step_results.push_back(res_t'{cur[ID_W-1:0], 1'b1, ST_OK, 1'b0});
						hits++;
					end else begin
						prev = cur;
					end
					cur = nxt;
				end
				if (hits == 0)
					step_results.push_back(res_t'{4'd0, 1'b0, ST_OK, 1'b1});
				else
					step_results[step_results.size()-1].last = 1'b1;
			end
			default: begin
				step_results.push_back(res_t'{id, 1'b0, ST_OK, 1'b1});
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result beat %0d: %s got %0d, want %0d", beats_seen, what, got,
			want);
		errors++;
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_op(logic [2:0] op, logic [ID_W-1:0] id, logic [EXP_W-1:0] expv,
			logic [DLY_W-1:0] dly, logic [EXP_W-1:0] nowv, bit typed, res_t want);
		while ($urandom_range(0, 99) < src_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {4'b0, nowv, dly, expv, id};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		timer_list_step(op, id, expv, dly, nowv);
		if (typed) begin
			step_results.delete();
			step_results.push_back(want);
		end
		foreach (step_results[i])
			due_results.push_back(step_results[i]);
		ops_sent++;
		@(negedge clk);
	endtask

	task automatic load_tick_rate(logic [TPS_W-1:0] rate);
		s_axis_tvalid = 1'b0;
		wait (due_results.size() == 0);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = rate;
		tick_rate = rate;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= dst_idle);

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (m_axis_tuser === 1'b1)
				fired_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("beat with nothing due, timer", m_axis_tdata[3:0], 0);
			end else begin
				want = due_results.pop_front();
				if (m_axis_tdata[3:0] !== want.id)
					report_mismatch("result_timer", m_axis_tdata[3:0], want.id);
				if (m_axis_tuser !== want.fired)
					report_mismatch("fired", m_axis_tuser, want.fired);
				if (m_axis_tdata[5:4] !== want.status)
					report_mismatch("status", m_axis_tdata[5:4], want.status);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				due_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	stim_row_t directed [25];

	initial begin
		logic [2:0]       op;
		logic [ID_W-1:0]  id;
		logic [EXP_W-1:0] expv;
		logic [DLY_W-1:0] dly;
		logic [EXP_W-1:0] nowv;
		logic [EXP_W-1:0] now_tick;
		logic [TPS_W-1:0] seg_rate [4];
		int               pick;

		directed = '{
			'{OP_SWEEP,   4'd3,  32'h0,        16'h0,    32'h0,        1'b1,
				res_t'{4'd0,  1'b0, ST_OK,        1'b1}},
			'{OP_CANCEL,  4'd5,  32'h0,        16'h0,    32'h0,        1'b1,
				res_t'{4'd5,  1'b0, ST_NOT_FOUND, 1'b1}},
			'{OP_ADD,     4'd0,  32'h0,        16'h0,    32'h0,        1'b1,
				res_t'{4'd0,  1'b0, ST_OK,        1'b1}},
			'{OP_ADD,     4'd15, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1,
				res_t'{4'd15, 1'b0, ST_OK,        1'b1}},
			'{OP_ADD,     4'd0,  32'd1234,     16'h0,    32'h0,        1'b1,
				res_t'{4'd0,  1'b0, ST_PENDING,   1'b1}},
			'{OP_ADD,     4'd7,  32'h80000000, 16'h0,    32'h0,        1'b0, '0},
			'{OP_MODIFY,  4'd3,  32'd100,      16'h0,    32'h0,        1'b0, '0},
			'{OP_MODIFY,  4'd7,  32'd50,       16'h0,    32'h0,        1'b0, '0},
			'{OP_SET_REL, 4'd9,  32'h0,        16'hFFFF, 32'hFFFFFFFF, 1'b0, '0},
			'{OP_SET_REL, 4'd3,  32'h0,        16'h0,    32'd1234,     1'b0, '0},
			'{3'd5,       4'd2,  32'hAAAAAAAA, 16'h5555, 32'h55555555, 1'b1,
				res_t'{4'd2,  1'b0, ST_OK,        1'b1}},
			'{3'd6,       4'd15, 32'h55555555, 16'hAAAA, 32'hAAAAAAAA, 1'b1,
				res_t'{4'd15, 1'b0, ST_OK,        1'b1}},
			'{3'd7,       4'd0,  32'h0,        16'h0,    32'h0,        1'b1,
				res_t'{4'd0,  1'b0, ST_OK,        1'b1}},
			'{OP_CANCEL,  4'd15, 32'h0,        16'h0,    32'h0,        1'b0, '0},
			'{OP_CANCEL,  4'd0,  32'h0,        16'h0,    32'h0,        1'b0, '0},
			'{OP_CANCEL,  4'd9,  32'h0,        16'h0,    32'h0,        1'b0, '0},
			'{OP_CANCEL,  4'd9,  32'h0,        16'h0,    32'h0,        1'b1,
				res_t'{4'd9,  1'b0, ST_NOT_FOUND, 1'b1}},
			'{OP_SWEEP,   4'd0,  32'h0,        16'h0,    32'd1000,     1'b0, '0},
			'{OP_ADD,     4'd1,  32'd10,       16'h0,    32'h0,        1'b0, '0},
			'{OP_ADD,     4'd2,  32'd20,       16'h0,    32'h0,        1'b0, '0},
			'{OP_ADD,     4'd12, 32'h7FFFFFFF, 16'h0,    32'h0,        1'b0, '0},
			'{OP_SWEEP,   4'd0,  32'h0,        16'h0,    32'h0,        1'b0, '0},
			'{OP_SWEEP,   4'd0,  32'h0,        16'h0,    32'h80000010, 1'b0, '0},
			'{OP_SET_REL, 4'd4,  32'h0,        16'hFFFF, 32'h0,        1'b0, '0},
			'{OP_SWEEP,   4'd0,  32'h0,        16'h0,    32'hFFFFFFFF, 1'b0, '0}
		};
		seg_rate = '{TPS_W'(0), TPS_W'(16383), TPS_W'(1), TPS_W'(10000)};

		foreach (armed[i]) begin
			armed[i] = 1'b0;
			exp_tick[i] = '0;
			link[i] = '0;
		end
		chain_head = END_PTR;
		chain_tail = END_PTR;
		tick_rate = TPS_RESET;
		src_idle = 32;
		dst_idle = 71;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[r])
			send_op(directed[r].op, directed[r].id, directed[r].expv, directed[r].dly,
				directed[r].nowv, directed[r].typed, directed[r].want);

		for (int seg = 0; seg < 4; seg++) begin
			load_tick_rate(seg_rate[seg]);
			src_idle = (seg == 0) ? 32 : (seg == 1) ? 71 : 0;
			dst_idle = (seg == 0) ? 71 : (seg == 1) ? 32 : 0;
			// second segment starts just short of the tick wrap
			now_tick = (seg == 1) ? 32'hFFFFFF00 : $urandom;
			for (int k = 0; k < RAND_PER_SEG; k++) begin
				if ($urandom_range(0, 99) < 10) begin
					op = 3'($urandom_range(0, 7));
					id = 4'($urandom_range(0, 15));
					expv = $urandom;
					dly = 16'($urandom_range(0, 65535));
					nowv = $urandom;
				end else begin
					now_tick = now_tick + 32'($urandom_range(0, 200));
					pick = $urandom_range(0, 99);
					op = (pick < 30) ? OP_ADD : (pick < 42) ? OP_MODIFY :
						(pick < 56) ? OP_SET_REL : (pick < 70) ? OP_CANCEL :
						(pick < 95) ? OP_SWEEP : 3'($urandom_range(5, 7));
					id = 4'($urandom_range(0, 15));
					expv = now_tick + 32'($urandom_range(0, 400)) - 32'd100;
					dly = ($urandom_range(0, 9) == 0) ? 16'hFFFF :
						16'($urandom_range(0, 3000));
					nowv = now_tick;
					if (op == OP_SWEEP && $urandom_range(0, 9) == 0)
						nowv = now_tick + 32'h40000000;
				end
				send_op(op, id, expv, dly, nowv, 1'b0, '0);
			end
		end

		s_axis_tvalid = 1'b0;
		wait (due_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d operations sent, %0d result beats checked, %0d of them fired timers",
			ops_sent, beats_seen, fired_seen);
		$display("tick rates covered: reset value, 0, 16383, 1 and 10000; stalls on both sides");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/ptl_pkg.sv
design/ptl_front.sv
design/ptl_cmd_fifo.sv
design/ptl_back.sv
design/pending_timer_list_core.sv
design/ptl_checker.sv
test/pending_timer_list_core_tb.sv
